// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the frustum cull block; empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds in the same cycle as the trigger
`define AFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition holds in the cycle after the trigger
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AFC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// shared constants and types of the aabb frustum cull test
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NUM_PLANES       = 6;

    // plane register packing
    localparam int PLANE_W = 64;
    localparam int COEF_W  = 16;
    localparam int A_LSB   = 48;
    localparam int B_LSB   = 32;
    localparam int C_LSB   = 16;
    localparam int D_LSB   = 0;

    localparam int CFG_INDEX_W = $clog2(NUM_PLANES);

    // signed product and full-width distance
    localparam int PROD_W = COORD_BITS + COEF_W;
    localparam int DIST_W = ((PROD_W + 2 > COEF_W + NORMAL_FRAC_BITS) ?
                             PROD_W + 2 : COEF_W + NORMAL_FRAC_BITS) + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PLANE_LEFT   = CFG_INDEX_W'(0),
        REG_PLANE_RIGHT  = CFG_INDEX_W'(1),
        REG_PLANE_BOTTOM = CFG_INDEX_W'(2),
        REG_PLANE_TOP    = CFG_INDEX_W'(3),
        REG_PLANE_NEAR   = CFG_INDEX_W'(4),
        REG_PLANE_FAR    = CFG_INDEX_W'(5)
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
    } box_t;

    // what one cell hands to the next
    typedef struct packed {
        box_t box;
        logic culled;
    } link_t;

endpackage

// ===== hdl/afc_if.sv =====
// ----------------------------------------------------------------------------
// afc_if
// valid/ready channels for boxes in and cull results out
// ----------------------------------------------------------------------------
interface afc_box_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [afc_pkg::COORD_BITS-1:0] min_x;
    logic signed [afc_pkg::COORD_BITS-1:0] min_y;
    logic signed [afc_pkg::COORD_BITS-1:0] min_z;
    logic signed [afc_pkg::COORD_BITS-1:0] max_x;
    logic signed [afc_pkg::COORD_BITS-1:0] max_y;
    logic signed [afc_pkg::COORD_BITS-1:0] max_z;

    modport source (
        output valid, min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );

    modport sink (
        input  valid, min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

interface afc_cull_if;
    logic valid;
    logic ready;
    logic culled;

    modport source (
        output valid, culled,
        input  ready
    );

    modport sink (
        input  valid, culled,
        output ready
    );
endinterface

// ===== hdl/afc_plane_cell.sv =====
// ----------------------------------------------------------------------------
// afc_plane_cell
// one frustum plane: holds its coefficients, tests the passing box against
// them in two register stages and ors the verdict into the running flag
// ----------------------------------------------------------------------------
module afc_plane_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           plane_we,
    input  logic [afc_pkg::PLANE_W-1:0]    plane_data,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  afc_pkg::link_t                 up_data,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output afc_pkg::link_t                 dn_data
);

    typedef struct packed {
        logic signed [afc_pkg::PROD_W-1:0] lo_x;
        logic signed [afc_pkg::PROD_W-1:0] hi_x;
        logic signed [afc_pkg::PROD_W-1:0] lo_y;
        logic signed [afc_pkg::PROD_W-1:0] hi_y;
        logic signed [afc_pkg::PROD_W-1:0] lo_z;
        logic signed [afc_pkg::PROD_W-1:0] hi_z;
    } prod_t;

    logic [afc_pkg::PLANE_W-1:0]         plane_reg;
    logic [afc_pkg::PLANE_W-1:0]         plane_next;
    logic signed [afc_pkg::COEF_W-1:0]   coef_a;
    logic signed [afc_pkg::COEF_W-1:0]   coef_b;
    logic signed [afc_pkg::COEF_W-1:0]   coef_c;
    logic signed [afc_pkg::COEF_W-1:0]   coef_d;

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    afc_pkg::box_t                       s1_box_reg;
    afc_pkg::box_t                       s1_box_next;
    logic                                s1_culled_reg;
    logic                                s1_culled_next;
    prod_t                               s1_prod_reg;
    prod_t                               s1_prod_next;
    logic                                s1_ready;

    logic                                s2_valid_reg;
    logic                                s2_valid_next;
    afc_pkg::box_t                       s2_box_reg;
    afc_pkg::box_t                       s2_box_next;
    logic                                s2_culled_reg;
    logic                                s2_culled_next;
    logic                                s2_ready;

    logic signed [afc_pkg::PROD_W-1:0]   max_x;
    logic signed [afc_pkg::PROD_W-1:0]   max_y;
    logic signed [afc_pkg::PROD_W-1:0]   max_z;
    logic signed [afc_pkg::DIST_W-1:0]   d_term;
    logic signed [afc_pkg::DIST_W-1:0]   dist_sum;
    logic                                behind;

    assign plane_next = plane_we ? plane_data : plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    assign coef_a = plane_reg[afc_pkg::A_LSB +: afc_pkg::COEF_W];
    assign coef_b = plane_reg[afc_pkg::B_LSB +: afc_pkg::COEF_W];
    assign coef_c = plane_reg[afc_pkg::C_LSB +: afc_pkg::COEF_W];
    assign coef_d = plane_reg[afc_pkg::D_LSB +: afc_pkg::COEF_W];

    // elastic handshake: a stage takes new data when empty or draining
    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    // stage 1: per-axis products for both box extremes
    always_comb
    begin
        s1_valid_next  = s1_ready ? up_valid : s1_valid_reg;
        s1_box_next    = s1_box_reg;
        s1_culled_next = s1_culled_reg;
        s1_prod_next   = s1_prod_reg;
        if (s1_ready)
        begin
            s1_box_next       = up_data.box;
            s1_culled_next    = up_data.culled;
            s1_prod_next.lo_x = afc_pkg::PROD_W'(coef_a) * afc_pkg::PROD_W'(up_data.box.min_x);
            s1_prod_next.hi_x = afc_pkg::PROD_W'(coef_a) * afc_pkg::PROD_W'(up_data.box.max_x);
            s1_prod_next.lo_y = afc_pkg::PROD_W'(coef_b) * afc_pkg::PROD_W'(up_data.box.min_y);
            s1_prod_next.hi_y = afc_pkg::PROD_W'(coef_b) * afc_pkg::PROD_W'(up_data.box.max_y);
            s1_prod_next.lo_z = afc_pkg::PROD_W'(coef_c) * afc_pkg::PROD_W'(up_data.box.min_z);
            s1_prod_next.hi_z = afc_pkg::PROD_W'(coef_c) * afc_pkg::PROD_W'(up_data.box.max_z);
        end
    end

    // stage 2: the farthest corner is the one with the largest term per axis,
    // so all eight corners are behind exactly when that corner is
    assign max_x    = (s1_prod_reg.hi_x > s1_prod_reg.lo_x) ? s1_prod_reg.hi_x : s1_prod_reg.lo_x;
    assign max_y    = (s1_prod_reg.hi_y > s1_prod_reg.lo_y) ? s1_prod_reg.hi_y : s1_prod_reg.lo_y;
    assign max_z    = (s1_prod_reg.hi_z > s1_prod_reg.lo_z) ? s1_prod_reg.hi_z : s1_prod_reg.lo_z;
    assign d_term   = afc_pkg::DIST_W'(coef_d) <<< afc_pkg::NORMAL_FRAC_BITS;
    assign dist_sum = afc_pkg::DIST_W'(max_x) + afc_pkg::DIST_W'(max_y)
                    + afc_pkg::DIST_W'(max_z) + d_term;
    assign behind   = dist_sum[afc_pkg::DIST_W-1] || (dist_sum == '0);

    always_comb
    begin
        s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
        s2_box_next    = s2_box_reg;
        s2_culled_next = s2_culled_reg;
        if (s2_ready)
        begin
            s2_box_next    = s1_box_reg;
            s2_culled_next = s1_culled_reg || behind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_box_reg    <= s1_box_next;
        s1_culled_reg <= s1_culled_next;
        s1_prod_reg   <= s1_prod_next;
        s2_box_reg    <= s2_box_next;
        s2_culled_reg <= s2_culled_next;
    end

    assign dn_valid       = s2_valid_reg;
    assign dn_data.box    = s2_box_reg;
    assign dn_data.culled = s2_culled_reg;

endmodule

// ===== hdl/aabb_frustum_cull_test.sv =====
// depth: a box passes through 6 cells, 2 register stages each, on its way to its result
// throughput: one box per cycle while results are taken; each cell's multiply stage and its
//   max/sum/compare stage both take a new box every cycle unless stalled by back-pressure
// reset: all plane registers clear to zero, so every box is culled until the
//   planes are written; the pipeline comes up empty and ready
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test
// eight-corner box versus view frustum test in fixed point. a box streams
// through a row of six plane cells; each cell tests it against its own plane
// and ors the result into a culled flag that travels with the box.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_frustum_cull_test (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [afc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [afc_pkg::PLANE_W-1:0]        cfg_data,
    afc_box_if.sink                            boxes,
    afc_cull_if.source                         result
);

    // link k feeds cell k; link NUM_PLANES is the result register
    logic [afc_pkg::NUM_PLANES:0] link_valid;
    logic [afc_pkg::NUM_PLANES:0] link_ready;
    afc_pkg::link_t               link_data [afc_pkg::NUM_PLANES+1];
    logic [afc_pkg::NUM_PLANES-1:0] plane_we;

    // register write decode; indices past the far plane are dropped
    always_comb
    begin
        plane_we = '0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                afc_pkg::REG_PLANE_LEFT:   plane_we[afc_pkg::REG_PLANE_LEFT]   = 1'b1;
                afc_pkg::REG_PLANE_RIGHT:  plane_we[afc_pkg::REG_PLANE_RIGHT]  = 1'b1;
                afc_pkg::REG_PLANE_BOTTOM: plane_we[afc_pkg::REG_PLANE_BOTTOM] = 1'b1;
                afc_pkg::REG_PLANE_TOP:    plane_we[afc_pkg::REG_PLANE_TOP]    = 1'b1;
                afc_pkg::REG_PLANE_NEAR:   plane_we[afc_pkg::REG_PLANE_NEAR]   = 1'b1;
                afc_pkg::REG_PLANE_FAR:    plane_we[afc_pkg::REG_PLANE_FAR]    = 1'b1;
                default:                   plane_we = '0;
            endcase
        end
    end

    // box transfer enters the chain with the flag clear
    assign link_valid[0]          = boxes.valid;
    assign boxes.ready            = link_ready[0];
    assign link_data[0].box.min_x = boxes.min_x;
    assign link_data[0].box.min_y = boxes.min_y;
    assign link_data[0].box.min_z = boxes.min_z;
    assign link_data[0].box.max_x = boxes.max_x;
    assign link_data[0].box.max_y = boxes.max_y;
    assign link_data[0].box.max_z = boxes.max_z;
    assign link_data[0].culled    = 1'b0;

    // row of plane cells; ready ripples back through the chain so a bubble
    // anywhere lets a new box in even while the result waits
    for (genvar i = 0; i < afc_pkg::NUM_PLANES; i++)
    begin : g_cell
        afc_plane_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .plane_we   (plane_we[i]),
            .plane_data (cfg_data),
            .up_valid   (link_valid[i]),
            .up_ready   (link_ready[i]),
            .up_data    (link_data[i]),
            .dn_valid   (link_valid[i+1]),
            .dn_ready   (link_ready[i+1]),
            .dn_data    (link_data[i+1])
        );
    end

    // last cell's output stage doubles as the result register
    assign result.valid                     = link_valid[afc_pkg::NUM_PLANES];
    assign result.culled                    = link_data[afc_pkg::NUM_PLANES].culled;
    assign link_ready[afc_pkg::NUM_PLANES]  = result.ready;

    // an empty result stage leaves every stage upstream free to move
    `AFC_ASSERT_NOW(a_empty_out_accepts, clk, rst_n, !result.valid, boxes.ready)
    // with the consumer taking results nothing in the chain can stall
    `AFC_ASSERT_NOW(a_draining_accepts, clk, rst_n, result.ready, boxes.ready)

endmodule

// ===== dv/afc_cull_compare.sv =====
// ----------------------------------------------------------------------------
// afc_cull_compare
// watches the plane write port and both channels, keeps its own copy of the
// six planes, works out the culled flag of every box and compares it in order
// ----------------------------------------------------------------------------
module afc_cull_compare
    import afc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PLANE_W-1:0]     cfg_data,
    afc_box_if                     boxes,
    afc_cull_if                    result,
    output int                     pending,
    output int                     errors
);

    localparam int NUM_CORNERS = 8;

    typedef struct {
        box_t box;
        logic culled;
    } verdict_t;

    logic [PLANE_W-1:0] planes [NUM_PLANES];
    verdict_t           verdicts [$];

    // exact distance of all eight corners against every plane
    function automatic logic box_culled(box_t b);
        longint lo [3];
        longint hi [3];
        longint a;
        longint bn;
        longint cn;
        longint d;
        longint corner_dist;
        int     behind;
        logic   hit;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        hit = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            a  = $signed(planes[p][A_LSB +: COEF_W]);
            bn = $signed(planes[p][B_LSB +: COEF_W]);
            cn = $signed(planes[p][C_LSB +: COEF_W]);
            d  = longint'($signed(planes[p][D_LSB +: COEF_W]))
                 * (longint'(1) << NORMAL_FRAC_BITS);
            behind = 0;
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                corner_dist = a  * (c[0] ? hi[0] : lo[0])
                            + bn * (c[1] ? hi[1] : lo[1])
                            + cn * (c[2] ? hi[2] : lo[2]) + d;
                if (corner_dist <= 0)
                    behind++;
            end
            if (behind == NUM_CORNERS)
                hit = 1'b1;
        end
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        box_t     b;
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
                planes[p] = '0;
            verdicts.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            // indexes past the last plane go nowhere
            if (cfg_we && cfg_index < NUM_PLANES)
                planes[cfg_index] = cfg_data;

            if (boxes.valid && boxes.ready)
            begin
                b = {boxes.min_x, boxes.min_y, boxes.min_z,
                     boxes.max_x, boxes.max_y, boxes.max_z};
                want.box    = b;
                want.culled = box_culled(b);
                verdicts.insert(verdicts.size(), want);
            end

            if (result.valid && result.ready)
            begin
                if (verdicts.size() == 0)
                begin
                    $display("%0t: culled result with no box outstanding: expected none, got %0b",
                             $time, result.culled);
                    errors <= errors + 1;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (result.culled !== want.culled)
                    begin
                        $display("%0t: culled mismatch for box (%0d,%0d,%0d)..(%0d,%0d,%0d): expected %0b, got %0b",
                                 $time, want.box.min_x, want.box.min_y, want.box.min_z,
                                 want.box.max_x, want.box.max_y, want.box.max_z,
                                 want.culled, result.culled);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= verdicts.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// frustum cull regression: programs the six planes through several settings
// (reset, hand-built cube, extreme coefficients, raw random, tilted), streams
// boxes with random gaps and receiver back-pressure, and takes the verdict
// from the compare module that runs beside the block
// ----------------------------------------------------------------------------
module tb;
    import afc_pkg::*;

    localparam int CLK_PERIOD        = 20;
    localparam int RESET_CYCLES      = 7;
    localparam int TIMEOUT_CYCLES    = 200000;
    localparam int DRAIN_CYCLES      = 30;      // pipeline is 12 deep
    localparam int LONG_STALL_CYCLES = 80;      // well past the pipeline depth
    localparam int PHASE_ITEMS       = 534;     // three phases, ~1600 boxes
    localparam int SETTING_ITEMS     = 100;     // boxes between plane changes
    localparam int STALL_AT_ITEM     = 20;

    // Q1.14 unit normal and coefficient extremes
    localparam logic signed [COEF_W-1:0] ONE      = 16'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7fff;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;

    // register indexes with no plane behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_LO = CFG_INDEX_W'(NUM_PLANES);
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_HI = '1;

    typedef enum int {
        PLANES_CUBE,
        PLANES_RAW,
        PLANES_EXTREME,
        PLANES_TILTED,
        PLANES_KINDS
    } plane_mix_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [PLANE_W-1:0]     cfg_data;
    int                     pending;
    int                     errors;

    // idle rates in percent and the long stall request count
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     stall_requests;

    logic [PLANE_W-1:0]     plane_set [NUM_PLANES];

    afc_box_if  boxes ();
    afc_cull_if result ();

    aabb_frustum_cull_test DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .boxes     (boxes),
        .result    (result)
    );

    afc_cull_compare u_compare (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .boxes     (boxes),
        .result    (result),
        .pending   (pending),
        .errors    (errors)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // helpers
    // --------------------------------------------------------------------

    function automatic logic [PLANE_W-1:0] pack_plane(
        input logic signed [COEF_W-1:0] a,
        input logic signed [COEF_W-1:0] b,
        input logic signed [COEF_W-1:0] c,
        input logic signed [COEF_W-1:0] d
    );
        return {a, b, c, d};
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic box_t make_box(input int x0, input int y0, input int z0,
                                      input int x1, input int y1, input int z1);
        box_t b;
        b.min_x = clamp_coord(x0);
        b.min_y = clamp_coord(y0);
        b.min_z = clamp_coord(z0);
        b.max_x = clamp_coord(x1);
        b.max_y = clamp_coord(y1);
        b.max_z = clamp_coord(z1);
        return b;
    endfunction

    // mostly small boxes near the frustum, some raw bit patterns, some inverted
    function automatic box_t random_box();
        int   roll;
        int   c [3];
        int   h [3];
        int   lo [3];
        int   hi [3];
        int   tmp;
        roll = $urandom_range(99);
        if (roll < 12)
            return box_t'({$urandom, $urandom, $urandom});
        for (int k = 0; k < 3; k++)
        begin
            c[k]  = int'($urandom_range(8192)) - 4096;
            h[k]  = int'($urandom_range(roll < 70 ? 255 : 2047));
            lo[k] = c[k] - h[k];
            hi[k] = c[k] + h[k];
            // inverted box: min above max on random axes
            if (roll < 20 && $urandom_range(1))
            begin
                tmp   = lo[k];
                lo[k] = hi[k];
                hi[k] = tmp;
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    function automatic logic signed [COEF_W-1:0] extreme_coef();
        case ($urandom_range(4))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return -16'sd1;
        endcase
    endfunction

    // axis-aligned cube of half size h around (ox, oy, oz)
    task automatic cube_planes(input int h, input int ox, input int oy, input int oz);
        plane_set[REG_PLANE_LEFT]   = pack_plane(ONE,    16'sd0, 16'sd0, COEF_W'(h - ox));
        plane_set[REG_PLANE_RIGHT]  = pack_plane(-ONE,   16'sd0, 16'sd0, COEF_W'(h + ox));
        plane_set[REG_PLANE_BOTTOM] = pack_plane(16'sd0, ONE,    16'sd0, COEF_W'(h - oy));
        plane_set[REG_PLANE_TOP]    = pack_plane(16'sd0, -ONE,   16'sd0, COEF_W'(h + oy));
        plane_set[REG_PLANE_NEAR]   = pack_plane(16'sd0, 16'sd0, ONE,    COEF_W'(h - oz));
        plane_set[REG_PLANE_FAR]    = pack_plane(16'sd0, 16'sd0, -ONE,   COEF_W'(h + oz));
    endtask

    task automatic random_planes(input plane_mix_t mix);
        case (mix)
            PLANES_CUBE:
                cube_planes(int'($urandom_range(256, 3000)),
                            int'($urandom_range(4000)) - 2000,
                            int'($urandom_range(4000)) - 2000,
                            int'($urandom_range(4000)) - 2000);
            PLANES_RAW:
                for (int p = 0; p < NUM_PLANES; p++)
                    plane_set[p] = {$urandom, $urandom};
            PLANES_EXTREME:
                for (int p = 0; p < NUM_PLANES; p++)
                    plane_set[p] = pack_plane(extreme_coef(), extreme_coef(),
                                              extreme_coef(), extreme_coef());
            default:
                for (int p = 0; p < NUM_PLANES; p++)
                    plane_set[p] = pack_plane(
                        COEF_W'(int'($urandom_range(32768)) - 16384),
                        COEF_W'(int'($urandom_range(32768)) - 16384),
                        COEF_W'(int'($urandom_range(32768)) - 16384),
                        COEF_W'(int'($urandom_range(8192)) - 4096));
        endcase
    endtask

    // write enable stays high across back-to-back writes; caller lowers it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [PLANE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // all six planes, then junk to the unused indexes so aliasing shows up
    task automatic load_planes();
        for (int p = 0; p < NUM_PLANES; p++)
            write_reg(CFG_INDEX_W'(p), plane_set[p]);
        write_reg(CFG_INDEX_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_INDEX_SPARE_HI, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    // one box transfer, with a random gap in front of it
    task automatic send_box(input box_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            boxes.valid <= 1'b0;
            @(posedge clk);
        end
        boxes.valid <= 1'b1;
        boxes.min_x <= b.min_x;
        boxes.min_y <= b.min_y;
        boxes.min_z <= b.min_z;
        boxes.max_x <= b.max_x;
        boxes.max_y <= b.max_y;
        boxes.max_z <= b.max_z;
        do
            @(posedge clk);
        while (!boxes.ready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_idle();
        boxes.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // random boxes; planes change every SETTING_ITEMS boxes while idle
    task automatic run_phase(input int n_items, input int s_pct, input int r_pct,
                             inout int setting);
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % SETTING_ITEMS == 0)
            begin
                wait_idle();
                random_planes(plane_mix_t'(setting % PLANES_KINDS));
                setting++;
                load_planes();
            end
            // long hold-off on the result side while boxes keep coming
            if (i % SETTING_ITEMS == STALL_AT_ITEM)
                stall_requests <= stall_requests + 1;
            send_box(random_box());
        end
    endtask

    // --------------------------------------------------------------------
    // result side: random ready, plus a long counted stall on request
    // --------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        int stalls_served;
        stall_left    = 0;
        stalls_served = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                result.ready <= 1'b0;
            else if (stall_requests != stalls_served)
            begin
                stalls_served = stall_requests;
                stall_left    = LONG_STALL_CYCLES;
                result.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // --------------------------------------------------------------------
    // stimulus and verdict
    // --------------------------------------------------------------------
    initial
    begin : stimulus
        int setting;
        setting        = 0;
        send_idle_pct  = 0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        boxes.valid    <= 1'b0;
        boxes.min_x    <= '0;
        boxes.min_y    <= '0;
        boxes.min_z    <= '0;
        boxes.max_x    <= '0;
        boxes.max_y    <= '0;
        boxes.max_z    <= '0;
        recv_idle_pct  <= 0;
        stall_requests <= 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // planes still zero after reset: every box is culled
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));

        // cube of half size 1000 around the origin
        wait_idle();
        cube_planes(1000, 0, 0, 0);
        load_planes();
        send_box(make_box(-10, -10, -10, 10, 10, 10));          // inside
        send_box(make_box(-2000, -5, -5, -1500, 5, 5));         // past left
        send_box(make_box(1500, -5, -5, 2000, 5, 5));           // past right
        send_box(make_box(-5, -2000, -5, 5, -1500, 5));         // below
        send_box(make_box(-5, 1500, -5, 5, 2000, 5));           // above
        send_box(make_box(-5, -5, -2000, 5, 5, -1500));         // in front of near
        send_box(make_box(-5, -5, 1500, 5, 5, 2000));           // beyond far
        send_box(make_box(-1200, -5, -5, -1000, 5, 5));         // touches left, distance 0
        send_box(make_box(-1200, -5, -5, -999, 5, 5));          // one unit over
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(500, 500, 500, -500, -500, -500));    // inverted, inside
        send_box(make_box(-1500, 0, 0, -2000, 1, 1));           // inverted, outside
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));

        // coefficient extremes; the rest are degenerate planes that never cull
        wait_idle();
        plane_set[REG_PLANE_LEFT]   = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        plane_set[REG_PLANE_RIGHT]  = pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        plane_set[REG_PLANE_BOTTOM] = pack_plane(16'sd0, 16'sd0, 16'sd0, 16'sd1);
        plane_set[REG_PLANE_TOP]    = pack_plane(16'sd0, 16'sd0, 16'sd0, 16'sd1);
        plane_set[REG_PLANE_NEAR]   = pack_plane(16'sd0, 16'sd0, 16'sd0, 16'sd1);
        plane_set[REG_PLANE_FAR]    = pack_plane(16'sd0, 16'sd0, 16'sd0, 16'sd1);
        load_planes();
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(0, 0, 0, 0, 0, 0));

        // random part: mostly receiver gaps, then mostly sender gaps, then full rate
        run_phase(PHASE_ITEMS, 37, 65, setting);
        run_phase(PHASE_ITEMS, 65, 37, setting);
        run_phase(PHASE_ITEMS, 0, 0, setting);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop in case a transfer never completes
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
